// ----- hw/rtl/tpbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbd_pkg - touch pad baseline detector package
// Field widths, register indexes, reset values and the result layout.
// ----------------------------------------------------------------------------
package tpbd_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int SCALED_W   = 14;
  localparam int BASE_W     = 16;
  localparam int SMALL_W    = 12;
  localparam int TRIP_W     = 14;
  localparam int WARM_W     = 8;
  localparam int LVL_W      = 18;
  localparam int PADIDX_W   = 3;
  localparam int MAP_W      = 5;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_ADDR_W-1:0] REG_TRIP   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HYST   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WARMUP = 2'd2;

  localparam logic [TRIP_W-1:0] TRIP_RST   = 14'd1000;
  localparam logic [TRIP_W-1:0] HYST_RST   = 14'd100;
  localparam logic [WARM_W-1:0] WARMUP_RST = 8'd160;

  // result word, fields listed from the highest bit down
  typedef struct packed {
    logic [1:0]          pad;
    logic [BASE_W-1:0]   baseline;
    logic [PADIDX_W-1:0] first_pressed;
    logic                any_pressed;
    logic [MAP_W-1:0]    pressed_map;
    logic                warming;
    logic                pressed;
    logic [PADIDX_W-1:0] pad_index;
  } result_t;

endpackage

// ----- hw/rtl/touch_pad_baseline_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_pad_baseline_detector - capacitive touch baseline/hysteresis detector
// Round-robin pad sampling, baseline tracking and press/release decision.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle unless the result side holds off. A sample
// sits in the input register after the edge that accepts it; the single-pass
// update moves it into the result register once that register is free, and it
// can be taken from there. All per-pad state lives in flip-flops and is read
// and written in that one update, so back-to-back samples never stall unless
// the result side holds off. The result register frees in the same cycle it is
// taken, so a full downstream handshake keeps the rate at one per cycle.
module touch_pad_baseline_detector
  import tpbd_pkg::*;
#(
  parameter int NUM_PADS   = 5,
  parameter int AVG_PERIOD = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] pad_index, [3] pressed,
                                            // [4] warming, [9:5] pressed_map,
                                            // [10] any_pressed,
                                            // [13:11] first_pressed,
                                            // [29:14] baseline
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PadW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
  localparam int RcW  = $clog2(AVG_PERIOD + 1);
  localparam logic [PadW-1:0] LastPad = PadW'(NUM_PADS - 1);
  localparam logic [RcW-1:0]  AvgTop  = RcW'(AVG_PERIOD);

  // configuration
  logic [TRIP_W-1:0] trip_r;
  logic [TRIP_W-1:0] hyst_r;

  // pad state
  logic [BASE_W-1:0] base_r [NUM_PADS];
  logic [NUM_PADS-1:0] flags_r, flags_nxt;
  logic [PadW-1:0] ptr_r, ptr_nxt;
  logic [WARM_W-1:0] warm_r, warm_nxt;
  logic [RcW-1:0] rc_r, rc_nxt;

  // pipeline
  logic                s1_valid_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic                out_valid_r;
  result_t             res_r, res_nxt;

  logic out_free, s2_fire, warm_wr;

  assign out_free   = !out_valid_r || out_tready;
  assign s2_fire    = s1_valid_r && out_free;
  assign in_tready  = !s1_valid_r || out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;
  assign warm_wr    = cfg_we && (cfg_addr == REG_WARMUP);

  // update datapath
  logic [SCALED_W-1:0] scaled;
  logic [BASE_W-1:0]   old_base, max_base, new_base;
  logic [SMALL_W-1:0]  base_div;
  logic signed [LVL_W-1:0] s_lvl, press_lvl, rel_lvl;
  logic                warming;
  logic [PadW+PADIDX_W-1:0]  pad_x, first_x;
  logic [NUM_PADS+MAP_W-1:0] map_x;
  logic [PadW-1:0]     first_idx;

  always_comb begin
    scaled    = {s1_sample_r, 4'b0000};
    old_base  = base_r[ptr_r];
    base_div  = old_base[BASE_W-1:4];
    s_lvl     = LVL_W'(scaled);
    press_lvl = $signed(LVL_W'(old_base)) - $signed(LVL_W'(trip_r));
    rel_lvl   = press_lvl + $signed(LVL_W'(hyst_r));
    max_base  = (BASE_W'(scaled) > old_base) ? BASE_W'(scaled) : old_base;
    warming   = (warm_r != '0);
    flags_nxt = flags_r;
    rc_nxt    = rc_r;
    warm_nxt  = warm_r;
    new_base  = old_base;
    if (warming) begin
      warm_nxt = warm_r - 1'b1;
      new_base = BASE_W'(scaled);
    end else begin
      if (s_lvl > rel_lvl) begin
        flags_nxt[ptr_r] = 1'b0;
      end else if (s_lvl < press_lvl) begin
        flags_nxt[ptr_r] = 1'b1;
      end
      if (ptr_r == '0) begin
        rc_nxt = (rc_r < AvgTop) ? rc_r + 1'b1 : '0;
      end
      new_base = max_base;
      if (rc_nxt == AvgTop) begin
        new_base = max_base + BASE_W'(s1_sample_r) - BASE_W'(base_div);
      end
    end
    ptr_nxt = (ptr_r == LastPad) ? '0 : ptr_r + 1'b1;

    first_idx = '0;
    for (int i = NUM_PADS - 1; i >= 0; i--) begin
      if (flags_nxt[i]) begin
        first_idx = PadW'(i);
      end
    end
    pad_x   = {{PADIDX_W{1'b0}}, ptr_r};
    first_x = {{PADIDX_W{1'b0}}, first_idx};
    map_x   = {{MAP_W{1'b0}}, flags_nxt};

    res_nxt               = '0;
    res_nxt.pad_index     = pad_x[PADIDX_W-1:0];
    res_nxt.pressed       = flags_nxt[ptr_r];
    res_nxt.warming       = warming;
    res_nxt.pressed_map   = map_x[MAP_W-1:0];
    res_nxt.any_pressed   = |flags_nxt;
    res_nxt.first_pressed = first_x[PADIDX_W-1:0];
    res_nxt.baseline      = new_base;
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trip_r      <= TRIP_RST;
      hyst_r      <= HYST_RST;
      warm_r      <= WARMUP_RST;
      flags_r     <= '0;
      ptr_r       <= '0;
      rc_r        <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_PADS; i++) begin
        base_r[i] <= '0;
      end
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s2_fire) begin
        flags_r       <= flags_nxt;
        ptr_r         <= ptr_nxt;
        rc_r          <= rc_nxt;
        base_r[ptr_r] <= new_base;
      end
      // a warm-up write restarts the count and wins over the update
      if (warm_wr) begin
        warm_r <= cfg_wdata[WARM_W-1:0];
      end else if (s2_fire) begin
        warm_r <= warm_nxt;
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_TRIP: trip_r <= cfg_wdata;
          REG_HYST: hyst_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sample_r <= in_tdata[SAMPLE_W-1:0];
    end
    if (s2_fire) begin
      res_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= LastPad)
    else $error("pad pointer out of range");

  a_warmup_count: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && warm_r != '0 && !cfg_we) |=> (warm_r == WARM_W'($past(warm_r) - 1'b1)))
    else $error("warm-up count did not step");

  a_first_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.any_pressed) |-> (res_r.first_pressed == '0 &&
                                             res_r.pressed_map == '0))
    else $error("first pressed set with no pad pressed");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - touch_pad_baseline_detector
// Streams converter samples into the detector and checks every result word
// against a cycle-free model of the pad baselines, press flags, warm-up count
// and averaging round. Directed cases cover the warm-up, press, release and
// threshold extremes; random traffic runs through several register settings
// under three back-pressure profiles.
// ----------------------------------------------------------------------------
module testbench;
  import tpbd_pkg::*;

  localparam int NUM_PADS       = 5;
  localparam int AVG_PERIOD     = 64;
  localparam int SAMPLE_MAX     = 1023;
  localparam int NUM_SEGMENTS   = 9;
  localparam int ITEMS_PER_SEG  = 160;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int MAX_REPORTS    = 100;

  // unmapped register index, writes must be dropped
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int unsigned send_idle_pct  = 10;
  int unsigned ready_idle_pct = 77;
  int unsigned mismatch_count = 0;

  // model state
  logic [BASE_W-1:0]   base_q [NUM_PADS];
  logic [NUM_PADS-1:0] flag_q;
  int unsigned         pad_ptr;
  int unsigned         warm_left;
  int unsigned         avg_round;
  logic [TRIP_W-1:0]   trip_q;
  logic [TRIP_W-1:0]   hyst_q;

  result_t pad_result_q [$];

  touch_pad_baseline_detector #(
    .NUM_PADS  (NUM_PADS),
    .AVG_PERIOD(AVG_PERIOD)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("touch_pad_baseline_detector: mismatch");
    $finish;
  end

  task automatic reset_pad_model();
    int i;
    for (i = 0; i < NUM_PADS; i++) base_q[i] = '0;
    flag_q    = '0;
    pad_ptr   = 0;
    warm_left = WARMUP_RST;
    avg_round = 0;
    trip_q    = TRIP_RST;
    hyst_q    = HYST_RST;
  endtask

  task automatic predict_pad_update(input logic [SAMPLE_W-1:0] raw, output result_t r);
    int unsigned         pad;
    logic [SCALED_W-1:0] scaled;
    logic [BASE_W-1:0]   old_base;
    logic [BASE_W-1:0]   next_base;
    int                  press_lvl;
    int                  release_lvl;
    logic                warming;
    int                  i;
    pad      = pad_ptr;
    scaled   = {raw, 4'b0000};
    old_base = base_q[pad];
    warming  = 1'b0;
    if (warm_left != 0) begin
      warm_left--;
      base_q[pad] = BASE_W'(scaled);
      warming     = 1'b1;
    end else begin
      press_lvl   = int'(old_base) - int'(trip_q);
      release_lvl = press_lvl + int'(hyst_q);
      if (int'(scaled) > release_lvl) flag_q[pad] = 1'b0;
      else if (int'(scaled) < press_lvl) flag_q[pad] = 1'b1;
      next_base = (BASE_W'(scaled) > old_base) ? BASE_W'(scaled) : old_base;
      if (pad == 0) avg_round = (avg_round < AVG_PERIOD) ? avg_round + 1 : 0;
      // averaging round: nudge toward the raw sample, wraps at 16 bits
      if (avg_round == AVG_PERIOD)
        next_base = next_base + BASE_W'(raw) - BASE_W'(old_base[BASE_W-1:4]);
      base_q[pad] = next_base;
    end
    pad_ptr = (pad + 1 >= NUM_PADS) ? 0 : pad + 1;

    r               = '0;
    r.pad_index     = PADIDX_W'(pad);
    r.pressed       = flag_q[pad];
    r.warming       = warming;
    r.pressed_map   = MAP_W'(flag_q);
    r.any_pressed   = |flag_q;
    r.first_pressed = '0;
    for (i = NUM_PADS - 1; i >= 0; i--)
      if (flag_q[i]) r.first_pressed = PADIDX_W'(i);
    r.baseline      = base_q[pad];
  endtask

  task automatic check_field(input string name, input logic [BASE_W-1:0] want,
                             input logic [BASE_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata);
      if (pad_result_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t ns: result expected none, got %0h", $time, out_tdata);
      end else begin
        want = pad_result_q.pop_front();
        check_field("pad_index", want.pad_index, got.pad_index);
        check_field("pressed", want.pressed, got.pressed);
        check_field("warming", want.warming, got.warming);
        check_field("pressed_map", want.pressed_map, got.pressed_map);
        check_field("any_pressed", want.any_pressed, got.any_pressed);
        check_field("first_pressed", want.first_pressed, got.first_pressed);
        check_field("baseline", want.baseline, got.baseline);
      end
    end
    out_tready <= ($urandom_range(99) >= ready_idle_pct);
  end

  // one sample request; tvalid stays high so back-to-back requests need no gap
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(sample);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pad_update(sample, want);
    pad_result_q.push_back(want);
  endtask

  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    while (pad_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_TRIP:   trip_q = data;
      REG_HYST:   hyst_q = data;
      REG_WARMUP: warm_left = data[WARM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // upper data bits are junk for the 8-bit warm-up register
  task automatic write_warmup(input logic [WARM_W-1:0] count);
    write_reg(REG_WARMUP, {(CFG_DATA_W - WARM_W)'($urandom), count});
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample(input int nominal);
    int          v;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50)
      v = nominal + int'($urandom_range(6)) - 3;
    else if (pick < 80)
      v = nominal - int'(trip_q) / 16 + 5 - int'($urandom_range(30));
    else if (pick < 95)
      v = nominal - int'($urandom_range((int'(trip_q) + int'(hyst_q)) / 16 + 5));
    else if (pick < 99)
      v = int'($urandom_range(nominal));
    else
      v = int'($urandom_range(SAMPLE_MAX));
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  task automatic test_reset_warmup();
    send_sample(10'd0);
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(10'h2AA);
    send_sample(10'h155);
    wait_for_idle();
  endtask

  task automatic test_press_release();
    int i;
    write_warmup(8'd5);
    write_reg(REG_TRIP, TRIP_RST);
    write_reg(REG_HYST, HYST_RST);
    for (i = 0; i < NUM_PADS; i++) send_sample(10'd600);
    send_sample(10'd500);   // well below press level
    send_sample(10'd540);   // inside hysteresis band, flag kept
    send_sample(10'd1023);  // baseline jumps up
    send_sample(10'd0);
    send_sample(10'd550);
    send_sample(10'd545);   // just above release level
    send_sample(10'd530);
    send_sample(10'd600);
    wait_for_idle();
    // warm-up restart keeps the flags
    write_warmup(8'd2);
    send_sample(10'd100);
    send_sample(10'd900);
    wait_for_idle();
  endtask

  task automatic test_register_extremes();
    write_warmup(8'd0);
    write_reg(REG_UNUSED, 14'h3FFF);
    write_reg(REG_TRIP, 14'h3FFF);
    write_reg(REG_HYST, 14'h0000);
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(10'd0);
    send_sample(10'd512);
    send_sample(10'd0);
    wait_for_idle();
    write_reg(REG_TRIP, 14'h0000);
    write_reg(REG_HYST, 14'h3FFF);
    send_sample(10'd0);
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(10'd300);
    send_sample(10'd300);
    wait_for_idle();
  endtask

  task automatic load_segment_setting(input int seg);
    logic [TRIP_W-1:0] t;
    logic [TRIP_W-1:0] h;
    logic [WARM_W-1:0] w;
    case (seg)
      0:       begin t = TRIP_RST; h = HYST_RST; w = 8'd10;  end
      1:       begin t = 14'd0;    h = 14'd0;    w = 8'd0;   end
      2:       begin t = 14'h3FFF; h = 14'h3FFF; w = 8'd255; end
      3:       begin t = 14'd400;  h = 14'h3FFF; w = 8'd5;   end
      4:       begin t = 14'd2000; h = 14'd500;  w = 8'd1;   end
      5:       begin t = 14'd160;  h = 14'd16;   w = 8'd0;   end
      default: begin
        t = TRIP_W'($urandom_range(3000));
        h = TRIP_W'($urandom_range(800));
        w = WARM_W'($urandom_range(20));
      end
    endcase
    write_reg(REG_TRIP, t);
    write_reg(REG_HYST, h);
    write_warmup(w);
  endtask

  task automatic test_random_traffic();
    int seg;
    int i;
    int nominal;
    for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
      wait_for_idle();
      case (seg / 3)
        0:       begin send_idle_pct = 10; ready_idle_pct = 77; end
        1:       begin send_idle_pct = 77; ready_idle_pct = 10; end
        default: begin send_idle_pct = 0;  ready_idle_pct = 0;  end
      endcase
      load_segment_setting(seg);
      nominal = $urandom_range(1000, 200);
      for (i = 0; i < ITEMS_PER_SEG; i++) begin
        // hold off mid-stream until the pipe is empty
        if (seg == 4 && i == ITEMS_PER_SEG / 2) wait_for_idle();
        send_sample(random_sample(nominal));
      end
    end
  endtask

  initial begin
    reset_pad_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_warmup();
    test_press_release();
    test_register_extremes();
    test_random_traffic();
    wait_for_idle();
    if (mismatch_count == 0) begin
      $display("touch_pad_baseline_detector: match");
    end else begin
      $display("touch_pad_baseline_detector: mismatch");
    end
    $finish;
  end

endmodule
